@@ design/msbp_pkg.sv @@
// msbp_pkg: shared types and constants of the msb-first bit packer
// no dependencies; used by the front, queue, back and top level modules
`timescale 1ns / 1ps

package msbp_pkg;

    localparam int FIELD_W         = 32;
    localparam int BIT_WIDTH_W     = 6;
    localparam int BYTE_W          = 8;
    localparam int PARTIAL_W       = 7;
    localparam int PARTIAL_CNT_W   = 3;
    localparam int MAX_FIELD_WIDTH = 32;
    localparam int WIDTH_LIMIT     = (MAX_FIELD_WIDTH < FIELD_W) ? MAX_FIELD_WIDTH : FIELD_W;
    localparam int S_TDATA_W       = 40;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = 2;
    localparam int QUEUE_CNT_W     = 3;
    localparam int BYTE_CNT_W      = 3;

    // one queue entry: the completed bytes of one item, right-aligned
    typedef struct packed {
        logic [FIELD_W-1:0]    bytes;
        logic [BYTE_CNT_W-1:0] count;
    } msbp_entry_t;

    // queue status as seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } msbp_qstat_t;

endpackage

@@ design/msb_first_bit_packer.sv @@
// msb_first_bit_packer: top level of the msb-first variable-length bit packer
// depends on msbp_pkg, msbp_front, msbp_queue, msbp_back
//
//   channel | direction | tdata (low bit up)                     | tuser / tlast
//   --------+-----------+----------------------------------------+---------------------
//   s_      | in        | field_bits[31:0], bit_width[37:32], pad | none
//   m_      | out       | byte_out[7:0]                           | tlast = last_byte
//
// the front takes one input transaction per cycle while the queue has room, bytes or not
// the back sends one byte per cycle while m_tready is high, and an item completes up to 4
// bytes of output; sustained rate is set by the byte output port
// m_tvalid rises once an item's bytes are queued and then popped into the back, if it is idle
// a four-entry queue lets the front keep accepting while the back stalls; s_tready drops when full
// synchronous active-low reset clears pending bits, queue pointers and m_tvalid; stored bytes are held
`timescale 1ns / 1ps

module msb_first_bit_packer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [msbp_pkg::S_TDATA_W-1:0]    s_tdata,   // field_bits[31:0], bit_width[37:32]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msbp_pkg::BYTE_W-1:0]       m_tdata,   // byte_out[7:0]
    output logic                              m_tlast
);
    import msbp_pkg::*;

    // front to queue
    logic        push;
    msbp_entry_t push_entry;
    // queue to back
    logic        pop;
    msbp_entry_t pop_entry;
    msbp_qstat_t qstat;

    // front: merge new bits with pending bits, split off whole bytes
    msbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .field_bits (s_tdata[FIELD_W-1:0]),
        .bit_width  (s_tdata[FIELD_W+BIT_WIDTH_W-1:FIELD_W]),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue decouples item acceptance from byte output
    msbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    // back: one byte per output transaction, last of an item marked
    msbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .byte_out  (m_tdata),
        .last_byte (m_tlast)
    );

`ifndef SYNTHESIS
    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !qstat.full)
        else $error("queue written while full");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    // a queue entry always carries at least one byte
    a_entry_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.count != '0))
        else $error("empty byte group queued");

    // reset leaves the output idle
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

@@ design/msbp_front.sv @@
// msbp_front: accepts items, merges them with the pending bits, splits off whole bytes
// depends on msbp_pkg
`timescale 1ns / 1ps

module msbp_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [msbp_pkg::FIELD_W-1:0]         field_bits,
    input  logic [msbp_pkg::BIT_WIDTH_W-1:0]     bit_width,
    input  msbp_pkg::msbp_qstat_t                qstat,
    output logic                                 push,
    output msbp_pkg::msbp_entry_t                push_entry
);
    import msbp_pkg::*;

    localparam int COMB_W = FIELD_W + PARTIAL_W;

    logic [PARTIAL_W-1:0]     partial_reg, partial_next;
    logic [PARTIAL_CNT_W-1:0] count_reg, count_next;

    logic [FIELD_W:0]         one_sh;
    logic [FIELD_W-1:0]       value_mask;
    logic [COMB_W-1:0]        combined;
    logic [COMB_W-1:0]        shifted;
    logic [BIT_WIDTH_W-1:0]   total;
    logic [PARTIAL_CNT_W-1:0] rem;
    logic [BYTE_CNT_W-1:0]    nbytes;
    logic [PARTIAL_W:0]       rem_sh;
    logic                     width_ok;
    logic                     accept;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign width_ok = (bit_width <= BIT_WIDTH_W'(WIDTH_LIMIT));

    always_comb begin
        one_sh     = (FIELD_W+1)'(1) << bit_width;
        value_mask = one_sh[FIELD_W-1:0] - FIELD_W'(1);
        combined   = ({{FIELD_W{1'b0}}, partial_reg} << bit_width)
                   | {{PARTIAL_W{1'b0}}, field_bits & value_mask};
        total      = BIT_WIDTH_W'(count_reg) + bit_width;
        rem        = total[PARTIAL_CNT_W-1:0];
        nbytes     = total[BIT_WIDTH_W-1:PARTIAL_CNT_W];
        shifted    = combined >> rem;
        rem_sh     = (PARTIAL_W+1)'(1) << rem;
    end

    assign push             = accept && width_ok && (nbytes != '0);
    assign push_entry.bytes = shifted[FIELD_W-1:0];
    assign push_entry.count = nbytes;

    always_comb begin
        partial_next = partial_reg;
        count_next   = count_reg;
        if (accept && width_ok) begin
            partial_next = combined[PARTIAL_W-1:0] & (rem_sh[PARTIAL_W-1:0] - PARTIAL_W'(1));
            count_next   = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            count_reg   <= '0;
        end else begin
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ design/msbp_queue.sv @@
// msbp_queue: short fifo of byte groups between front and back
// depends on msbp_pkg
`timescale 1ns / 1ps

module msbp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  msbp_pkg::msbp_entry_t push_entry,
    input  logic                  pop,
    output msbp_pkg::msbp_entry_t pop_entry,
    output msbp_pkg::msbp_qstat_t qstat
);
    import msbp_pkg::*;

    msbp_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] fill_reg, fill_next;

    assign qstat.full  = (fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign pop_entry   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        fill_next   = fill_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ design/msbp_back.sv @@
// msbp_back: takes byte groups from the queue and sends them one byte per transaction
// depends on msbp_pkg
`timescale 1ns / 1ps

module msbp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msbp_pkg::msbp_qstat_t         qstat,
    input  msbp_pkg::msbp_entry_t         pop_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msbp_pkg::BYTE_W-1:0]   byte_out,
    output logic                          last_byte
);
    import msbp_pkg::*;

    localparam logic [BYTE_CNT_W-1:0] ONE_LEFT = BYTE_CNT_W'(1);

    logic                     valid_reg, valid_next;
    logic [FIELD_W-1:0]       bytes_reg, bytes_next;
    logic [BYTE_CNT_W-1:0]    left_reg, left_next;
    logic                     done;

    assign out_valid = valid_reg;
    assign last_byte = (left_reg == ONE_LEFT);
    assign done      = !valid_reg || (out_ready && last_byte);
    assign pop       = done && !qstat.empty;

    // earliest byte sits highest among the ones still left
    always_comb begin
        unique case (left_reg)
            BYTE_CNT_W'(4): byte_out = bytes_reg[31:24];
            BYTE_CNT_W'(3): byte_out = bytes_reg[23:16];
            BYTE_CNT_W'(2): byte_out = bytes_reg[15:8];
            BYTE_CNT_W'(1): byte_out = bytes_reg[7:0];
            default:        byte_out = '0;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        bytes_next = bytes_reg;
        left_next  = left_reg;
        if (pop) begin
            valid_next = 1'b1;
            bytes_next = pop_entry.bytes;
            left_next  = pop_entry.count;
        end else if (done) begin
            valid_next = 1'b0;
        end else if (out_ready) begin
            left_next  = left_reg - ONE_LEFT;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ verif/msb_first_bit_packer_tb.sv @@
// msb_first_bit_packer_tb: self-checking bench for the msb-first bit packer
// depends on msbp_pkg and msb_first_bit_packer; a local model predicts every byte
// directed corner items, then random traffic under source and sink stalls
`timescale 1ns / 1ps

module msb_first_bit_packer_tb;

    import msbp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int QUIET_LIMIT = 5000;  // cycles with no transaction on either side
    localparam int LONG_HOLD   = 300;   // sink hold-off used to fill the queue
    localparam int TAIL_CYCLES = 20;

    // one expected byte on the m_ side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // field_bits[31:0], bit_width[37:32], zero pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;        // byte_out[7:0]
    logic                 m_tlast;

    // model state: bits still waiting for a whole byte
    logic [PARTIAL_W-1:0]     pend_bits = '0;
    logic [PARTIAL_CNT_W-1:0] pend_cnt  = '0;
    packed_byte_t             bytes_due[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int err_cnt       = 0;
    int fields_in     = 0;
    int bytes_seen    = 0;
    int ignored_cnt   = 0;
    int empty_cnt     = 0;
    int four_byte_cnt = 0;

    msb_first_bit_packer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // append the low width bits msb first and queue every byte that completes
    function automatic void pack_field_bits(input logic [FIELD_W-1:0] bits,
                                            input logic [BIT_WIDTH_W-1:0] width);
        logic [BYTE_W-1:0] acc;
        int                cnt;
        int                k;
        int                first;
        packed_byte_t      done;
        if (width > WIDTH_LIMIT) begin
            // out-of-range width: dropped without touching the pending bits
            ignored_cnt++;
            return;
        end
        if (width == 0) empty_cnt++;
        acc   = {1'b0, pend_bits};
        cnt   = pend_cnt;
        first = bytes_due.size();
        for (k = width; k > 0; k--) begin
            acc = {acc[BYTE_W-2:0], bits[k-1]};
            cnt++;
            if (cnt == BYTE_W) begin
                done.data = acc;
                done.last = 1'b0;
                bytes_due.push_back(done);
                acc = '0;
                cnt = 0;
            end
        end
        // the final byte of this item carries tlast
        if (bytes_due.size() > first) bytes_due[$].last = 1'b1;
        if (bytes_due.size() - first == 4) four_byte_cnt++;
        pend_bits = acc[PARTIAL_W-1:0];
        pend_cnt  = cnt[PARTIAL_CNT_W-1:0];
    endfunction

    // input side first, so a byte that leaves in the same cycle finds its expectation
    always @(posedge aclk) begin : byte_checker
        packed_byte_t want;
        if (aresetn && s_tvalid && s_tready) begin
            fields_in++;
            pack_field_bits(s_tdata[FIELD_W-1:0], s_tdata[FIELD_W +: BIT_WIDTH_W]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            bytes_seen++;
            if (bytes_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected byte, got data %02h last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = bytes_due.pop_front();
                if (m_tdata !== want.data) begin
                    err_cnt++;
                    $display("%0t: byte_out mismatch, expected %02h got %02h",
                             $time, want.data, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    err_cnt++;
                    $display("%0t: last_byte mismatch, expected %0b got %0b",
                             $time, want.last, m_tlast);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // sink: random stalls, or a long hold-off counted here when one is requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    // offer one item and return at the edge that takes it; valid stays high
    // unless the next call decides to idle
    task automatic offer_field(input logic [FIELD_W-1:0] bits,
                               input logic [BIT_WIDTH_W-1:0] width);
        if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - FIELD_W - BIT_WIDTH_W){1'b0}}, width, bits};
        do @(posedge aclk); while (!s_tready);
    endtask

    // source goes quiet until every predicted byte has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (bytes_due.size() != 0);
    endtask

    task automatic test_directed_corners();
        src_idle_pct  = 0;
        sink_idle_pct = 30;
        offer_field(32'hFFFF_FFFF, 6'd0);   // zero width, nothing appended
        offer_field(32'hFFFF_FFFF, 6'd1);   // one pending bit
        offer_field(32'h0000_0000, 6'd6);   // seven pending, still no byte
        offer_field(32'hFFFF_FFFF, 6'd32);  // 39 bits: four bytes, seven left
        offer_field(32'h1234_5678, 6'd33);  // just over the limit, dropped
        offer_field(32'hFFFF_FFFF, 6'd63);  // all width bits set, dropped
        offer_field(32'h0000_0001, 6'd1);   // completes a byte from the pending bits
        offer_field(32'h0000_00A5, 6'd8);   // byte aligned
        offer_field(32'hDEAD_BEEF, 6'd32);
        offer_field(32'h0000_0000, 6'd32);
        offer_field(32'hAAAA_AAAA, 6'd32);
        offer_field(32'h5555_5555, 6'd31);  // leaves seven pending
        offer_field(32'h01FF_FFFF, 6'd25);  // tops up to exactly four bytes
        offer_field(32'hFFFF_FFF0, 6'd4);   // bits above the width must not leak in
        offer_field(32'hFFFF_FFFD, 6'd2);
        offer_field(32'h8000_0005, 6'd3);
        offer_field(32'h0000_0009, 6'd5);
        offer_field(32'hFFFF_FF80, 6'd7);
        offer_field(32'h8000_0000, 6'd32);  // single set bit at the top
        offer_field(32'h0001_0000, 6'd17);
        offer_field(32'hC3C3_C3C3, 6'd40);  // mid-range out-of-limit width
        offer_field(32'h0000_7E00, 6'd15);
        wait_drained();
    endtask

    task automatic run_random_traffic(input int n_items);
        logic [FIELD_W-1:0]     bits;
        logic [BIT_WIDTH_W-1:0] width;
        int                     pick;
        repeat (n_items) begin
            bits = $urandom();
            pick = $urandom_range(99, 0);
            if (pick < 4) width = BIT_WIDTH_W'($urandom_range(63, 33));
            else if (pick < 10) width = '0;
            else if (pick < 40) width = BIT_WIDTH_W'($urandom_range(32, 24));
            else width = BIT_WIDTH_W'($urandom_range(32, 1));
            offer_field(bits, width);
        end
    endtask

    // sink stalls for a long stretch while the source keeps pushing wide items,
    // so the queue fills and s_tready has to drop
    task automatic test_queue_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_left     = LONG_HOLD;
        repeat (24) offer_field($urandom(), 6'd32);
        wait_drained();
    endtask

    task automatic test_slow_sink();
        src_idle_pct  = 15;
        sink_idle_pct = 84;
        run_random_traffic(90);
        wait_drained();
    endtask

    task automatic test_slow_source();
        src_idle_pct  = 84;
        sink_idle_pct = 15;
        run_random_traffic(90);
        wait_drained();
    endtask

    task automatic test_full_rate();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_traffic(90);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_queue_backpressure();
        test_slow_sink();
        test_slow_source();
        test_full_rate();
        // let any stray byte show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d items (%0d zero width, %0d out of range, %0d four-byte)",
                 fields_in, empty_cnt, ignored_cnt, four_byte_cnt);
        $display("%0d bytes checked under sink hold-off, both stall mixes and full rate",
                 bytes_seen);
        if (err_cnt == 0) begin
            $display("msb_first_bit_packer_tb: PASS");
        end else begin
            $display("msb_first_bit_packer_tb: FAIL");
        end
        $finish;
    end

    // watchdog: too long without any transaction means the block is stuck
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("%0t: timeout, %0d bytes still expected", $time, bytes_due.size());
        $display("msb_first_bit_packer_tb: FAIL");
        $finish;
    end

endmodule
